/* rtl/core/rpc_pkg.sv */
// Shared types, constants and factor tables for the Robinson canvas projection.
package rpc_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int PIXEL_FRAC_BITS = 4;

    localparam int LON_W  = 17;
    localparam int LAT_W  = 16;
    localparam int DIM_W  = 12;
    localparam int OUT_W  = 16;
    localparam int FAC_W  = 17;
    localparam int BAND_W = 5;

    localparam logic [BAND_W-1:0] LAST_BAND = 5'd17;

    localparam logic [DIM_W-1:0] CANVAS_WIDTH_RST  = 12'd1024;
    localparam logic [DIM_W-1:0] CANVAS_HEIGHT_RST = 12'd512;

    localparam logic [0:0] CFG_CANVAS_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_CANVAS_HEIGHT = 1'b1;

    // floor(v/5) = (v * RECIP5) >> 22 for v < 2^22
    localparam logic [19:0] RECIP5 = 20'd838861;
    // floor(v/45) = (v * RECIP45) >> 28 for v < 45 * 2^16
    localparam logic [22:0] RECIP45 = 23'd5965233;
    localparam int X_SAT_V = 45 * 65536;

    typedef struct packed {
        logic                    valid;
        logic signed [LON_W-1:0] lon;
        logic                    lat_neg;
        logic [FAC_W-1:0]        fx;
        logic [FAC_W-1:0]        fy;
    } t_factors;

    function automatic logic [FAC_W-1:0] factor_x(input logic [BAND_W-1:0] idx);
        logic [FAC_W-1:0] v;
        case (idx)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd65444;
            5'd2:  v = 17'd65234;
            5'd3:  v = 17'd64881;
            5'd4:  v = 17'd64369;
            5'd5:  v = 17'd63767;
            5'd6:  v = 17'd62915;
            5'd7:  v = 17'd61781;
            5'd8:  v = 17'd60398;
            5'd9:  v = 17'd58733;
            5'd10: v = 17'd56879;
            5'd11: v = 17'd54723;
            5'd12: v = 17'd52337;
            5'd13: v = 17'd49788;
            5'd14: v = 17'd47094;
            5'd15: v = 17'd44119;
            5'd16: v = 17'd40718;
            5'd17: v = 17'd37500;
            5'd18: v = 17'd34878;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [FAC_W-1:0] factor_y(input logic [BAND_W-1:0] idx);
        logic [FAC_W-1:0] v;
        case (idx)
            5'd0:  v = 17'd0;
            5'd1:  v = 17'd4063;
            5'd2:  v = 17'd8126;
            5'd3:  v = 17'd12190;
            5'd4:  v = 17'd16253;
            5'd5:  v = 17'd20316;
            5'd6:  v = 17'd24379;
            5'd7:  v = 17'd28443;
            5'd8:  v = 17'd32493;
            5'd9:  v = 17'd36510;
            5'd10: v = 17'd40475;
            5'd11: v = 17'd44361;
            5'd12: v = 17'd48143;
            5'd13: v = 17'd51793;
            5'd14: v = 17'd55280;
            5'd15: v = 17'd58563;
            5'd16: v = 17'd61565;
            5'd17: v = 17'd63970;
            5'd18: v = 17'd65536;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/rpc_factor.sv */
// Latitude banding and table interpolation of the X and Y factors (three stages).
module rpc_factor #(
    parameter int COORD_FRAC_BITS = rpc_pkg::COORD_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [rpc_pkg::LON_W-1:0] i_longitude,
    input  logic signed [rpc_pkg::LAT_W-1:0] i_latitude,
    output rpc_pkg::t_factors              o_factors
);
    localparam int C       = COORD_FRAC_BITS;
    localparam int R_W     = C + 3;
    localparam int NUM_W   = C + 20;
    localparam int NS_W    = C + 23;
    localparam int LAT_MAX = 90 << C;
    localparam int HALF_D  = 5 << (C - 1);
    localparam int BW      = rpc_pkg::BAND_W;
    localparam int FW      = rpc_pkg::FAC_W;

    // stage 1: |lat| clamp, band, remainder
    logic [15:0]    alat, alat_c;
    logic [16:0]    lat_neg_ext;
    logic [6:0]     deg;
    logic [14:0]    bprod;
    logic [BW-1:0]  band_raw, band;
    logic [31:0]    rfull;

    always_comb begin
        lat_neg_ext = 17'(-{i_latitude[15], i_latitude});
        alat = i_latitude[15] ? lat_neg_ext[15:0] : 16'(i_latitude);
        alat_c = (32'(alat) > 32'(LAT_MAX)) ? 16'(LAT_MAX) : alat;
        deg = 7'(alat_c >> C);
        bprod = 15'(deg) * 15'd205;
        band_raw = bprod[14:10];
        band = (band_raw > rpc_pkg::LAST_BAND) ? rpc_pkg::LAST_BAND : band_raw;
        rfull = 32'(alat_c) - ((32'(band) * 32'd5) << C);
    end

    logic                            r_v1;
    logic signed [rpc_pkg::LON_W-1:0] r_lon1;
    logic                            r_neg1;
    logic [BW-1:0]                   r_band1;
    logic [R_W-1:0]                  r_r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_lon1  <= i_longitude;
        r_neg1  <= i_latitude[15];
        r_band1 <= band;
        r_r1    <= rfull[R_W-1:0];
    end

    // stage 2: t0*D + (t1 - t0)*r + D/2
    logic [FW-1:0]          tx0, tx1, ty0, ty1;
    logic signed [17:0]     dx, dy;
    logic signed [R_W:0]    rs;
    logic signed [R_W+18:0] px, py;
    logic [NUM_W-1:0]       basex, basey;
    logic [NS_W-1:0]        sumx, sumy;

    always_comb begin
        tx0 = rpc_pkg::factor_x(r_band1);
        tx1 = rpc_pkg::factor_x(r_band1 + 5'd1);
        ty0 = rpc_pkg::factor_y(r_band1);
        ty1 = rpc_pkg::factor_y(r_band1 + 5'd1);
        dx = $signed({1'b0, tx1}) - $signed({1'b0, tx0});
        dy = $signed({1'b0, ty1}) - $signed({1'b0, ty0});
        rs = $signed({1'b0, r_r1});
        px = dx * rs;
        py = dy * rs;
        basex = (NUM_W'(tx0) * NUM_W'(5)) << C;
        basey = (NUM_W'(ty0) * NUM_W'(5)) << C;
        sumx = NS_W'(basex) + NS_W'(px) + NS_W'(HALF_D);
        sumy = NS_W'(basey) + NS_W'(py) + NS_W'(HALF_D);
    end

    logic                            r_v2;
    logic signed [rpc_pkg::LON_W-1:0] r_lon2;
    logic                            r_neg2;
    logic [NUM_W-1:0]                r_numx2, r_numy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_lon2  <= r_lon1;
        r_neg2  <= r_neg1;
        r_numx2 <= sumx[NUM_W-1:0];
        r_numy2 <= sumy[NUM_W-1:0];
    end

    // stage 3: divide by D = 5 << C
    logic [39:0] qx, qy;
    rpc_pkg::t_factors n_fac, r_fac;

    always_comb begin
        qx = 40'(r_numx2[NUM_W-1:C]) * 40'(rpc_pkg::RECIP5);
        qy = 40'(r_numy2[NUM_W-1:C]) * 40'(rpc_pkg::RECIP5);
        n_fac.valid   = r_v2;
        n_fac.lon     = r_lon2;
        n_fac.lat_neg = r_neg2;
        n_fac.fx      = qx[38:22];
        n_fac.fy      = qy[38:22];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fac.valid <= 1'b0;
        end else begin
            r_fac.valid <= n_fac.valid;
        end
        r_fac.lon     <= n_fac.lon;
        r_fac.lat_neg <= n_fac.lat_neg;
        r_fac.fx      <= n_fac.fx;
        r_fac.fy      <= n_fac.fy;
    end

    assign o_factors = r_fac;

endmodule

/* rtl/core/rpc_scale.sv */
// Projection and canvas scaling with rounding and saturation (four stages).
module rpc_scale #(
    parameter int COORD_FRAC_BITS = rpc_pkg::COORD_FRAC_BITS,
    parameter int PIXEL_FRAC_BITS = rpc_pkg::PIXEL_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rpc_pkg::t_factors             i_factors,
    input  logic [rpc_pkg::DIM_W-1:0]     i_canvas_width,
    input  logic [rpc_pkg::DIM_W-1:0]     i_canvas_height,
    output logic                          o_done,
    output logic [rpc_pkg::OUT_W-1:0]     o_canvas_x,
    output logic [rpc_pkg::OUT_W-1:0]     o_canvas_y,
    output logic                          o_point_valid
);
    localparam int C     = COORD_FRAC_BITS;
    localparam int P     = PIXEL_FRAC_BITS;
    localparam int DW    = rpc_pkg::DIM_W;
    localparam int OW    = rpc_pkg::OUT_W;
    localparam int S_W   = (((C + 24) > 33) ? (C + 24) : 33) + 2;
    localparam int SP_W  = S_W - 1;
    localparam int LO_W  = SP_W / 2;
    localparam int HI_W  = SP_W - LO_W;
    localparam int PLO_W = LO_W + DW;
    localparam int PHI_W = HI_W + DW;
    localparam int P_W   = SP_W + DW + 1;
    localparam int NX_W  = P_W + P + 1;
    localparam int YN_W  = 30 + P + 1;
    localparam logic [S_W-1:0]  X_OFS = S_W'(180) << (C + 16);
    localparam logic [NX_W-1:0] XHALF = NX_W'(45) << (C + 18);

    // stage 4: s = lon*fx + 180 deg, yn*H
    logic signed [34:0]    lp;
    logic signed [S_W-1:0] s4;
    logic [17:0]           yn;

    always_comb begin
        lp = i_factors.lon * $signed({1'b0, i_factors.fx});
        s4 = S_W'(lp) + $signed(X_OFS);
        yn = i_factors.lat_neg ? (18'd65536 + 18'(i_factors.fy))
                               : (18'd65536 - 18'(i_factors.fy));
    end

    logic                  r_v4;
    logic signed [S_W-1:0] r_s4;
    logic [29:0]           r_ymul4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= i_factors.valid;
        end
        r_s4    <= s4;
        r_ymul4 <= 30'(yn) * 30'(i_canvas_height);
    end

    // stage 5: split s*W, finish y
    logic [SP_W-1:0] spos;
    logic [YN_W-1:0] ynum;
    logic [YN_W-1:0] yq;
    logic [OW-1:0]   ysat;

    always_comb begin
        spos = (!r_s4[S_W-1] && (r_s4 != '0)) ? r_s4[SP_W-1:0] : '0;
        ynum = (YN_W'(r_ymul4) << P) + YN_W'(65536);
        yq = ynum >> 17;
        ysat = (yq > YN_W'(16'hFFFF)) ? 16'hFFFF : yq[OW-1:0];
    end

    logic                 r_v5;
    logic [PLO_W-1:0]     r_plo5;
    logic [PHI_W-1:0]     r_phi5;
    logic [OW-1:0]        r_y5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_plo5 <= PLO_W'(spos[LO_W-1:0]) * PLO_W'(i_canvas_width);
        r_phi5 <= PHI_W'(spos[SP_W-1:LO_W]) * PHI_W'(i_canvas_width);
        r_y5   <= ysat;
    end

    // stage 6: sum partials, round, coarse divide by 2^(C+19)
    logic [P_W-1:0]  prod;
    logic [NX_W-1:0] xnum, xv;

    always_comb begin
        prod = (P_W'(r_phi5) << LO_W) + P_W'(r_plo5);
        xnum = (NX_W'(prod) << P) + XHALF;
        xv = xnum >> (C + 19);
    end

    logic        r_v6;
    logic        r_sat6;
    logic [21:0] r_xv6;
    logic [OW-1:0] r_y6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        r_sat6 <= (xv >= NX_W'(rpc_pkg::X_SAT_V));
        r_xv6  <= xv[21:0];
        r_y6   <= r_y5;
    end

    // stage 7: divide by 45, output register
    logic [44:0] xq;
    logic        cfg_ok;

    always_comb begin
        xq = 45'(r_xv6) * 45'(rpc_pkg::RECIP45);
        cfg_ok = (i_canvas_width != '0) && (i_canvas_height != '0);
    end

    logic          r_done;
    logic [OW-1:0] r_x7, r_y7;
    logic          r_pv7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v6;
        end
        r_x7  <= !cfg_ok ? '0 : (r_sat6 ? 16'hFFFF : xq[43:28]);
        r_y7  <= !cfg_ok ? '0 : r_y6;
        r_pv7 <= cfg_ok;
    end

    assign o_done        = r_done;
    assign o_canvas_x    = r_x7;
    assign o_canvas_y    = r_y7;
    assign o_point_valid = r_pv7;

endmodule

/* rtl/core/robinson_projection_to_canvas.sv */
// Top level of the Robinson projection onto a configurable canvas.
// Throughput: one request per cycle; o_busy is never raised, no stalls.
// Seven register stages: banding, interpolation, divide by band width,
// projection, split multiply by width, rounding, divide by 45.
// Synchronous active-low reset clears stage valids and sets canvas 1024 x 512.
module robinson_projection_to_canvas #(
    parameter int COORD_FRAC_BITS = rpc_pkg::COORD_FRAC_BITS,
    parameter int PIXEL_FRAC_BITS = rpc_pkg::PIXEL_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic signed [rpc_pkg::LON_W-1:0] i_longitude,
    input  logic signed [rpc_pkg::LAT_W-1:0] i_latitude,
    input  logic                             i_cfg_we,
    input  logic [0:0]                       i_cfg_index,
    input  logic [rpc_pkg::DIM_W-1:0]        i_cfg_data,
    output logic                             o_done,
    output logic [rpc_pkg::OUT_W-1:0]        o_canvas_x,
    output logic [rpc_pkg::OUT_W-1:0]        o_canvas_y,
    output logic                             o_point_valid
);
    logic [rpc_pkg::DIM_W-1:0] r_canvas_width, r_canvas_height;
    rpc_pkg::t_factors         factors;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= rpc_pkg::CANVAS_WIDTH_RST;
            r_canvas_height <= rpc_pkg::CANVAS_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rpc_pkg::CFG_CANVAS_WIDTH:  r_canvas_width  <= i_cfg_data;
                rpc_pkg::CFG_CANVAS_HEIGHT: r_canvas_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    rpc_factor #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_factor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_start && !o_busy),
        .i_longitude (i_longitude),
        .i_latitude  (i_latitude),
        .o_factors   (factors)
    );

    rpc_scale #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS),
        .PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)
    ) u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_factors       (factors),
        .i_canvas_width  (r_canvas_width),
        .i_canvas_height (r_canvas_height),
        .o_done          (o_done),
        .o_canvas_x      (o_canvas_x),
        .o_canvas_y      (o_canvas_y),
        .o_point_valid   (o_point_valid)
    );

endmodule
